### rtl/core/piecewise_linear_power_curve_assert.svh
// Assertion macros for the heater power curve RTL.
`ifndef PIECEWISE_LINEAR_POWER_CURVE_ASSERT_SVH
`define PIECEWISE_LINEAR_POWER_CURVE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PLPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define PLPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/core/plpc_pkg.sv
// Types, curve breakpoints and constants for the heater power curve.
`default_nettype none
package plpc_pkg;

	localparam int NumPts  = 11;
	localparam int NumSegs = NumPts - 1;
	localparam int SegW    = $clog2(NumSegs);

	typedef logic signed [15:0] temp_t;
	typedef logic [14:0]        power_t;
	typedef logic signed [11:0] delta_t;
	typedef logic [SegW-1:0]    seg_t;

	typedef struct packed {
		power_t power;
		logic   clamped;
	} plpc_result_t;

	localparam power_t CapReset = 15'd14080;

	// Breakpoint temperatures, signed Q8.8 degrees
	localparam temp_t TempPt [NumPts] = '{
		16'sd2560, 16'sd3584, 16'sd4608, 16'sd5120, 16'sd5632, 16'sd6144,
		16'sd6656, 16'sd7168, 16'sd7680, 16'sd8192, 16'sd8448
	};

	// Breakpoint powers, unsigned Q7.8 percent
	localparam power_t PwrPt [NumPts] = '{
		15'd16640, 15'd14848, 15'd13056, 15'd12032, 15'd11008, 15'd9984,
		15'd8960,  15'd8192,  15'd7424,  15'd6400,  15'd5632
	};

	// Power step across each segment
	localparam delta_t PwrDelta [NumSegs] = '{
		-12'sd1792, -12'sd1792, -12'sd1024, -12'sd1024, -12'sd1024,
		-12'sd1024, -12'sd768,  -12'sd768,  -12'sd1024, -12'sd768
	};

	// 8 plus log2 of the segment span in degrees
	localparam logic [3:0] SegShift [NumSegs] = '{
		4'd10, 4'd10, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd8
	};

endpackage
`default_nettype wire

### rtl/core/plpc_if.sv
// Valid/ready channels for temperature requests and power results.
`default_nettype none
interface plpc_temp_if;
	logic             valid;
	logic             ready;
	plpc_pkg::temp_t  room_temperature;

	modport source (output valid, output room_temperature, input ready);
	modport sink (input valid, input room_temperature, output ready);
endinterface

interface plpc_power_if;
	logic             valid;
	logic             ready;
	plpc_pkg::power_t power_percent;
	logic             was_clamped;

	modport source (output valid, output power_percent, output was_clamped, input ready);
	modport sink (input valid, input power_percent, input was_clamped, output ready);
endinterface
`default_nettype wire

### rtl/core/plpc_curve.sv
// Segment lookup, linear interpolation and clamping of one temperature.
`default_nettype none
module plpc_curve (
	input  wire plpc_pkg::temp_t        temperature,
	input  wire plpc_pkg::power_t       cap,
	output plpc_pkg::plpc_result_t      result
);

	plpc_pkg::seg_t      seg;
	logic                below;
	logic                above;
	logic signed [16:0]  diff_wide;
	logic [9:0]          offset;
	logic signed [22:0]  prod;
	logic signed [22:0]  shifted;
	logic signed [17:0]  interp;
	logic signed [17:0]  curve_val;
	logic signed [17:0]  cap_ext;

	always_comb begin
		seg = '0;
		// breakpoints ascend, so the last one passed names the segment
		for (int i = 1; i < plpc_pkg::NumSegs; i++) begin
			if (temperature >= plpc_pkg::TempPt[i]) begin
				seg = plpc_pkg::SegW'(i);
			end
		end
	end

	assign below     = temperature <= plpc_pkg::TempPt[0];
	assign above     = temperature >= plpc_pkg::TempPt[plpc_pkg::NumPts-1];
	assign diff_wide = 17'(temperature) - 17'(plpc_pkg::TempPt[seg]);
	// inside a segment the offset is below 4 degrees
	assign offset    = diff_wide[9:0];
	assign prod      = 23'($signed({1'b0, offset})) * 23'(plpc_pkg::PwrDelta[seg]);
	// arithmetic shift floors toward minus infinity
	assign shifted   = prod >>> plpc_pkg::SegShift[seg];
	assign interp    = 18'(shifted) + $signed({3'b000, plpc_pkg::PwrPt[seg]});
	assign cap_ext   = $signed({3'b000, cap});

	always_comb begin
		if (below) begin
			curve_val = $signed({3'b000, plpc_pkg::PwrPt[0]});
		end else if (above) begin
			curve_val = $signed({3'b000, plpc_pkg::PwrPt[plpc_pkg::NumPts-1]});
		end else begin
			curve_val = interp;
		end
	end

	always_comb begin
		if (curve_val > cap_ext) begin
			result.power   = cap;
			result.clamped = 1'b1;
		end else if (curve_val < 18'sd0) begin
			result.power   = '0;
			result.clamped = 1'b1;
		end else begin
			result.power   = curve_val[14:0];
			result.clamped = 1'b0;
		end
	end

endmodule
`default_nettype wire

### rtl/core/piecewise_linear_power_curve.sv
// An accepted request is loaded into the input register; its result is then loaded into
// the result register, from which the sink takes it.
// Throughput: one request per cycle while the sink does not stall; the whole curve is
// evaluated combinationally between the input register and the result register.
// A stalled result register holds while the input register still takes one more request.
// Reset clears both valid flags and sets the power cap to 55 percent.
`default_nettype none
module piecewise_linear_power_curve (
	input  wire                   clk,
	input  wire                   arst_n,
	plpc_temp_if.sink             temp_in,
	plpc_power_if.source          power_out,
	input  wire                   cfg_wr_en,
	input  wire plpc_pkg::power_t cfg_wr_data
);

	`include "piecewise_linear_power_curve_assert.svh"

	plpc_pkg::power_t       cap_q;
	logic                   valid_s1;
	plpc_pkg::temp_t        temp_s1;
	logic                   valid_s2;
	plpc_pkg::plpc_result_t result_s2;
	plpc_pkg::plpc_result_t result;
	logic                   adv_s2;

	assign adv_s2        = !valid_s2 || power_out.ready;
	assign temp_in.ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= plpc_pkg::CapReset;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (temp_in.ready) begin
				valid_s1 <= temp_in.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (temp_in.valid && temp_in.ready) begin
			temp_s1 <= temp_in.room_temperature;
		end
		if (adv_s2) begin
			result_s2 <= result;
		end
	end

	plpc_curve u_curve (
		.temperature (temp_s1),
		.cap         (cap_q),
		.result      (result)
	);

	assign power_out.valid         = valid_s2;
	assign power_out.power_percent = result_s2.power;
	assign power_out.was_clamped   = result_s2.clamped;

	// hold a result that the sink has not taken
	`PLPC_ASSERT_NEXT(a_result_held, clk, arst_n, valid_s2 && !power_out.ready, valid_s2)
	// hold a request that cannot move on
	`PLPC_ASSERT_NEXT(a_s1_held, clk, arst_n, valid_s1 && !adv_s2,
		valid_s1 && $stable(temp_s1))
	// an unlimited value always lies on the curve's own range
	`PLPC_ASSERT_NOW(a_unclamped_range, clk, arst_n, valid_s2 && !result_s2.clamped,
		result_s2.power >= 15'd5632 && result_s2.power <= 15'd16640)

endmodule
`default_nettype wire

### sim/piecewise_linear_power_curve_tb.sv
// Self-checking testbench for the heater power curve: random and corner temperatures, several caps.
`timescale 1ns / 100ps

module piecewise_linear_power_curve_tb;

	localparam int CycleLimit = 200000;
	localparam int NumPhases  = 9;
	localparam int PhaseItems = 145;

	localparam plpc_pkg::temp_t ProbeTemps [22] = '{
		16'sh8000, 16'sh7fff, 16'sd0,    -16'sd1,   16'sd2559, 16'sd2560,
		16'sd2561, 16'sd3583, 16'sd3584, 16'sd4608, 16'sd5000, 16'sd5120,
		16'sd5632, 16'sd6144, 16'sd6656, 16'sd7000, 16'sd7168, 16'sd7680,
		16'sd8192, 16'sd8447, 16'sd8448, 16'sd8449
	};

	// Expected powers in request order, with its own copy of the cap
	class power_tracker;
		plpc_pkg::plpc_result_t awaited[$];
		int                     cap;
		int                     errors;

		function new();
			cap    = plpc_pkg::CapReset;
			errors = 0;
		endfunction

		function plpc_pkg::plpc_result_t curve_power(plpc_pkg::temp_t t);
			int                     tv, p, prod, span, i;
			bit                     done;
			plpc_pkg::plpc_result_t r;
			tv   = t;
			p    = int'(plpc_pkg::PwrPt[plpc_pkg::NumPts-1]);
			done = 0;
			if (tv <= int'(plpc_pkg::TempPt[0])) begin
				p = int'(plpc_pkg::PwrPt[0]);
			end else if (tv < int'(plpc_pkg::TempPt[plpc_pkg::NumPts-1])) begin
				for (i = 0; i < plpc_pkg::NumSegs; i++) begin
					if (!done && tv < int'(plpc_pkg::TempPt[i+1])) begin
						span = int'(plpc_pkg::TempPt[i+1]) - int'(plpc_pkg::TempPt[i]);
						prod = (tv - int'(plpc_pkg::TempPt[i])) *
							(int'(plpc_pkg::PwrPt[i+1]) - int'(plpc_pkg::PwrPt[i]));
						// span is a power of two, so an arithmetic shift floors the quotient
						p    = int'(plpc_pkg::PwrPt[i]) + (prod >>> $clog2(span));
						done = 1;
					end
				end
			end
			r.clamped = 1'b0;
			if (p > cap) begin
				p         = cap;
				r.clamped = 1'b1;
			end
			if (p < 0) begin
				p         = 0;
				r.clamped = 1'b1;
			end
			r.power = plpc_pkg::power_t'(p);
			return r;
		endfunction

		function void note_request(plpc_pkg::temp_t t);
			awaited.push_back(curve_power(t));
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(plpc_pkg::power_t power, logic clamped);
			plpc_pkg::plpc_result_t exp_r;
			if (awaited.size() == 0) begin
				report($sformatf("result power=%0d clamped=%0b with no request waiting",
					power, clamped));
				return;
			end
			exp_r = awaited.pop_front();
			if (power !== exp_r.power)
				report($sformatf("power_percent %0d, expected %0d", power, exp_r.power));
			if (clamped !== exp_r.clamped)
				report($sformatf("was_clamped %0b, expected %0b", clamped, exp_r.clamped));
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	plpc_pkg::power_t cfg_wr_data;
	int               source_idle_pct;
	int               sink_idle_pct;
	int               cycle_count;

	power_tracker tracker;

	plpc_temp_if  temp_if ();
	plpc_power_if power_if ();

	piecewise_linear_power_curve dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.temp_in     (temp_if),
		.power_out   (power_if),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #10 clk = ~clk;

	task automatic send_temperature(plpc_pkg::temp_t t);
		while ($urandom_range(99) < source_idle_pct) begin
			temp_if.valid <= 1'b0;
			@(posedge clk);
		end
		temp_if.valid            <= 1'b1;
		temp_if.room_temperature <= t;
		do
			@(posedge clk);
		while (!temp_if.ready);
		tracker.note_request(t);
	endtask

	// Drop valid and hold until every awaited result has come back
	task automatic wait_for_results();
		temp_if.valid <= 1'b0;
		@(posedge clk);
		while (tracker.awaited.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_power_cap(int value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= plpc_pkg::power_t'(value);
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		tracker.cap  = value;
	endtask

	function automatic plpc_pkg::temp_t random_temperature();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return plpc_pkg::temp_t'($urandom_range(8704, 2304));
		else if (pick < 80)
			return plpc_pkg::temp_t'(int'(plpc_pkg::TempPt[$urandom_range(plpc_pkg::NumPts-1)])
				+ $urandom_range(4) - 2);
		else
			return plpc_pkg::temp_t'($urandom_range(65535));
	endfunction

	// Receiver: check at each edge, then pick the next ready
	initial begin
		power_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && power_if.valid && power_if.ready)
				tracker.check_result(power_if.power_percent, power_if.was_clamped);
			power_if.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("** piecewise_linear_power_curve: FAILED **");
		$finish;
	end

	initial begin
		int caps [NumPhases];
		int ph, n, k;
		tracker                  = new();
		clk                      = 1'b0;
		arst_n                   = 1'b0;
		cfg_wr_en                = 1'b0;
		cfg_wr_data              = '0;
		temp_if.valid            = 1'b0;
		temp_if.room_temperature = '0;
		source_idle_pct          = 19;
		sink_idle_pct            = 48;
		caps = '{0, 32767, 25600, 13056, 16640, 0, 5632, 0, 14080};
		caps[5] = $urandom_range(32767);
		caps[7] = $urandom_range(16640, 5632);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corners under the reset cap
		for (k = 0; k < 22; k++)
			send_temperature(ProbeTemps[k]);
		wait_for_results();

		for (ph = 0; ph < NumPhases; ph++) begin
			case (ph / 3)
				0: begin
					source_idle_pct = 19;
					sink_idle_pct   = 48;
				end
				1: begin
					source_idle_pct = 48;
					sink_idle_pct   = 19;
				end
				default: begin
					source_idle_pct = 0;
					sink_idle_pct   = 0;
				end
			endcase
			write_power_cap(caps[ph]);
			// Breakpoints first, so a power equal to the cap is hit when the cap is a breakpoint power
			for (k = 0; k < plpc_pkg::NumPts; k++)
				send_temperature(plpc_pkg::TempPt[k]);
			for (n = 0; n < PhaseItems; n++) begin
				if (n == PhaseItems / 2 || $urandom_range(299) == 0)
					wait_for_results();
				send_temperature(random_temperature());
			end
			wait_for_results();
		end

		repeat (8) @(posedge clk);
		if (tracker.awaited.size() != 0)
			tracker.report($sformatf("%0d results never arrived", tracker.awaited.size()));
		if (tracker.errors == 0)
			$display("** piecewise_linear_power_curve: PASSED **");
		else
			$display("** piecewise_linear_power_curve: FAILED **");
		$finish;
	end

endmodule
